### rtl/blsd_pkg.sv
package blsd_pkg;

    // Bytes of one symbol group, at most four
    localparam int unsigned GROUP_BYTES = 4;

    // One queue entry: the result words caused by one input word
    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] bytes;     // result bytes, entry 0 first
        logic [2:0]                  count;     // number of valid bytes, 1..4
        logic                        strm_end;  // last group of the string
    } group_t;

    // Push side of the group queue
    typedef struct packed {
        logic   valid;
        group_t group;
    } push_t;

endpackage

### rtl/byte_level_symbol_decoder_core.sv
// Byte-level symbol decoder. Bytes of an encoded token string come in one word
// per cycle and are grouped into UTF-8 style symbols (lead byte sets length
// 1..4, continuation bytes unchecked). Each complete symbol is mapped back to
// its raw byte (code points 33-126, 161-172, 174-255 map to themselves,
// 256-323 to the unmapped bytes 0-32, 127-160, 173); an unmapped symbol passes
// through raw. in_last flushes: held bytes are reparsed and a truncated
// symbol's lead byte passes raw. The front stage takes one input word per
// cycle and pushes the result bytes of that word as one group into a
// QUEUE_DEPTH entry queue; the back stage drains one result word per cycle
// while out_ready holds. Input rate is one word per cycle while the queue has
// room; sustained rate is bounded by the back stage at one result byte per
// cycle. From input to first result a word passes the queue write and then
// the output register.
module byte_level_symbol_decoder_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_end
);

    blsd_pkg::push_t  push;
    logic             push_ready;
    logic             pop;
    logic             head_valid;
    blsd_pkg::group_t head;

    // front: holds partial symbol, classifies and decodes
    blsd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .push_ready (push_ready),
        .push       (push)
    );

    // decouples input acceptance from result draining
    blsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: serializes each group, one result word per cycle while out_ready holds
    blsd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .out_end    (out_end)
    );

endmodule

### rtl/blsd_front.sv
module blsd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            push_ready,
    output blsd_pkg::push_t push
);

    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    // Symbol length from the lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] l;
        if (c < ASCII_LIMIT)
            l = 3'd1;
        else if ((c & 8'hE0) == 8'hC0)
            l = 3'd2;
        else if ((c & 8'hF0) == 8'hE0)
            l = 3'd3;
        else
            l = 3'd4;
        return l;
    endfunction

    // Code point of a 2..4 byte symbol mapped back to one raw byte
    function automatic logic [8:0] map_symbol(input logic [3:0][7:0] s,
                                              input logic [2:0] len);
        logic [20:0] x;
        logic [6:0]  k;
        logic        hit;
        logic [7:0]  b;
        unique case (len)
            3'd2:    x = {10'd0, s[0][4:0], s[1][5:0]};
            3'd3:    x = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            default: x = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        endcase
        k   = x[6:0] ^ 7'd0;
        hit = 1'b0;
        b   = x[7:0];
        if ((x >= 21'd33 && x <= 21'd126) || (x >= 21'd161 && x <= 21'd172) ||
            (x >= 21'd174 && x <= 21'd255)) begin
            hit = 1'b1;
        end
        else if (x >= 21'd256 && x <= 21'd323) begin
            // x - 256 fits in seven bits over this range
            k   = 7'(x - 21'd256);
            hit = 1'b1;
            if (k <= 7'd32)
                b = {1'b0, k};
            else if (k <= 7'd66)
                b = 8'({1'b0, k} + 8'd94);
            else
                b = 8'd173;
        end
        return {hit, b};
    endfunction

    logic [2:0][7:0] held_reg;
    logic [1:0]      held_cnt_reg;
    logic [2:0]      sym_len_reg;

    logic [3:0][7:0] sbuf;
    logic [2:0]      cnt;
    logic [2:0]      len;
    logic            fire;
    logic            accept;

    logic [3:0][2:0] lead_l;
    logic [3:0]      fits;
    logic [3:0]      mapped;
    logic [3:0][7:0] mbyte;

    logic [3:0][7:0] obytes;
    logic [2:0]      ocnt;
    logic [2:0]      raw_until;
    logic [2:0]      skip_until;

    // Held bytes followed by the new byte
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (j < 3 && 2'(j) < held_cnt_reg)
                sbuf[j] = held_reg[j[1:0]];
            else if (3'(j) == {1'b0, held_cnt_reg})
                sbuf[j] = in_byte;
            else
                sbuf[j] = 8'd0;
        end
    end

    assign cnt = {1'b0, held_cnt_reg} + 3'd1;

    always_comb
    begin
        if (held_cnt_reg == 2'd0)
            len = lead_length(in_byte);
        else if (sym_len_reg >= 3'd1 && sym_len_reg <= 3'd4)
            len = sym_len_reg;
        else
            len = lead_length(sbuf[0]);
    end

    // One decoder per possible symbol start
    for (genvar p = 0; p < 4; p++)
    begin : g_start
        logic [3:0][7:0] win;
        logic [8:0]      dec;
        for (genvar i = 0; i < 4; i++)
        begin : g_win
            if (p + i < 4)
            begin : g_in
                assign win[i] = sbuf[p+i];
            end
            else
            begin : g_out
                assign win[i] = 8'd0;
            end
        end
        assign lead_l[p] = lead_length(sbuf[p]);
        assign fits[p]   = (4'(p) + {1'b0, lead_l[p]}) <= {1'b0, cnt};
        assign dec       = map_symbol(win, lead_l[p]);
        assign mapped[p] = (lead_l[p] != 3'd1) && dec[8];
        assign mbyte[p]  = (lead_l[p] == 3'd1) ? sbuf[p] : dec[7:0];
    end

    // Walk the bytes from the start; also covers the plain complete-symbol case
    always_comb
    begin
        obytes     = '0;
        ocnt       = 3'd0;
        raw_until  = 3'd0;
        skip_until = 3'd0;
        for (int j = 0; j < 4; j++)
        begin
            if (3'(j) < cnt)
            begin
                if (3'(j) < raw_until)
                begin
                    obytes[ocnt[1:0]] = sbuf[j];
                    ocnt = ocnt + 3'd1;
                end
                else if (3'(j) < skip_until)
                begin
                    ocnt = ocnt;
                end
                else if (fits[j] && mapped[j])
                begin
                    obytes[ocnt[1:0]] = mbyte[j];
                    ocnt       = ocnt + 3'd1;
                    skip_until = 3'(j) + lead_l[j];
                end
                else if (fits[j])
                begin
                    obytes[ocnt[1:0]] = sbuf[j];
                    ocnt      = ocnt + 3'd1;
                    raw_until = 3'(j) + lead_l[j];
                end
                else
                begin
                    // truncated symbol: lead byte raw, reparse from next byte
                    obytes[ocnt[1:0]] = sbuf[j];
                    ocnt = ocnt + 3'd1;
                end
            end
        end
    end

    assign fire     = in_last || (cnt >= len);
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    assign push.valid          = accept && fire;
    assign push.group.bytes    = obytes;
    assign push.group.count    = ocnt;
    assign push.group.strm_end = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            sym_len_reg  <= 3'd0;
        end
        else if (accept)
        begin
            if (fire)
            begin
                held_cnt_reg <= 2'd0;
                sym_len_reg  <= 3'd0;
            end
            else
            begin
                held_cnt_reg <= cnt[1:0];
                sym_len_reg  <= len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !fire)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (2'(j) == held_cnt_reg)
                    held_reg[j] <= in_byte;
            end
        end
    end

endmodule

### rtl/blsd_queue.sv
module blsd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  blsd_pkg::push_t  push,
    output logic             push_ready,
    input  logic             pop,
    output logic             head_valid,
    output blsd_pkg::group_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    blsd_pkg::group_t   mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.group;
    end

endmodule

### rtl/blsd_back.sv
module blsd_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  blsd_pkg::group_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             out_end
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_end_reg;
    logic       load;
    logic       is_last;

    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign is_last = ({1'b0, idx_reg} + 3'd1) >= head.count;
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.bytes[idx_reg];
            out_last_reg <= is_last;
            out_end_reg  <= is_last && head.strm_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_end   = out_end_reg;

endmodule
